// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg: shared types for the buddy block allocator
// Payload structs, status codes, granule table entry, controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	// order field width covers every supported arena order
	localparam int ORD_W  = 5;
	localparam int NEED_W = 17;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_TOOBIG  = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [15:0] request_size;
		logic [13:0] free_offset;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] data_offset;
		logic [3:0]  block_order;
	} out_t;

	// one granule table entry
	typedef struct packed {
		logic             head;
		logic             free;
		logic [ORD_W-1:0] order;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ_PTR,
		OP_READ_G,
		OP_READ_BUDDY,
		OP_SCAN,
		OP_SPLIT,
		OP_GRANT,
		OP_CHECK,
		OP_MERGE,
		OP_RELEASE,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t st;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic too_big;
		logic k_big;
		logic pre_bad;
		logic scan_done;
		logic found;
		logic split_more;
		logic head_ok;
		logic k_in;
		logic merge_ok;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_SC_RD,
		S_SC_EV,
		S_SPLIT,
		S_FR_RD,
		S_FR_EV,
		S_BD_RD,
		S_BD_EV,
		S_RELEASE,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

// ----- src/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator: binary buddy allocator over one granule table
// Allocate picks the lowest-address free block of the smallest fitting order
// and splits it down; free merges with free buddies upward.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data  (action, size, offset)
//   out      out  out_valid / out_ready  out_data (status, offset, order)
//
// Steps: an allocate walks the block list, reading (S_SC_RD) and evaluating
// (S_SC_EV) each block headed in the arena, then splits in S_SPLIT once per
// order above the request. A free reads and checks its block, then reads each
// buddy and merges while it is free. Setup (S_PRE) and result (S_FIN) come too.
// Reset: table valid bits clear at once; no clearing pass.
// A finished result waits in the output register; the next transaction is
// taken as soon as the result is loaded there.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator #(
	parameter int ARENA_ORDER  = 14,
	parameter int MIN_ORDER    = 6,
	parameter int HEADER_BYTES = 64,
	parameter int BUDDY_LIMIT  = 512
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  bba_pkg::in_t  in_data,
	output logic          out_valid,
	input  wire           out_ready,
	output bba_pkg::out_t out_data
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and arithmetic
	bba_dp #(
		.ARENA_ORDER  (ARENA_ORDER),
		.MIN_ORDER    (MIN_ORDER),
		.HEADER_BYTES (HEADER_BYTES),
		.BUDDY_LIMIT  (BUDDY_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ----- src/bba_dp.sv -----
// ----------------------------------------------------------------------------
// bba_dp: allocator datapath
// Granule table memory with per-entry valid bits, scan/split/merge registers
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
	parameter int ARENA_ORDER  = 14,
	parameter int MIN_ORDER    = 6,
	parameter int HEADER_BYTES = 64,
	parameter int BUDDY_LIMIT  = 512
) (
	input  wire             clk,
	input  wire             arst_n,
	input  bba_pkg::in_t    in_data,
	input  bba_pkg::cmd_t   cmd,
	output bba_pkg::sts_t   sts,
	output bba_pkg::out_t   out_data
);
	import bba_pkg::*;

	localparam int GW    = ARENA_ORDER - MIN_ORDER;
	localparam int NGRAN = 1 << GW;

	localparam logic [ORD_W-1:0] ORD_MIN   = ORD_W'(MIN_ORDER);
	localparam logic [ORD_W-1:0] ORD_ARENA = ORD_W'(ARENA_ORDER);

	// granule table and valid bits
	entry_t           mem_q [NGRAN];
	logic [NGRAN-1:0] vld_q;

	entry_t           rd_q;
	logic             rd_vld_q;
	logic             rd_zero_q;

	logic             act_q;
	logic             too_big_q;
	logic             k_big_q;
	logic             pre_bad_q;
	logic [ORD_W-1:0] k_q;
	logic [ORD_W-1:0] j_q;
	logic [GW-1:0]    ptr_q;
	logic [GW-1:0]    g_q;
	logic             found_q;
	out_t             res_q;

	entry_t           ent;
	logic [NEED_W-1:0] need_c;
	logic [ORD_W-1:0] k_c;
	int               addr_c;
	logic             pre_bad_c;
	logic             hit_c;
	logic [GW:0]      nxt_c;
	logic [GW-1:0]    buddy_c;
	logic [GW-1:0]    lo_c;
	logic [GW-1:0]    hi_c;
	logic             rd_en;
	logic [GW-1:0]    rd_addr;
	logic             we;
	logic [GW-1:0]    wa;
	entry_t           wd;
	logic [31:0]      off_c;

	// entry seen through its valid bit; unwritten entries read as reset
	always_comb begin
		if (rd_vld_q) begin
			ent = rd_q;
		end else if (rd_zero_q) begin
			ent = '{head: 1'b1, free: 1'b1, order: ORD_ARENA};
		end else begin
			ent = '0;
		end
	end

	// request decode: size class and free address checks
	always_comb begin
		need_c = NEED_W'(in_data.request_size) + NEED_W'(HEADER_BYTES);
		k_c    = ORD_W'(NEED_W);
		for (int i = NEED_W; i >= MIN_ORDER; i--) begin
			if (32'(need_c) <= (32'd1 << i)) begin
				k_c = ORD_W'(i);
			end
		end
		addr_c    = int'(in_data.free_offset) - HEADER_BYTES;
		pre_bad_c = (int'(in_data.free_offset) < HEADER_BYTES)
			|| ((addr_c & ((1 << MIN_ORDER) - 1)) != 0)
			|| ((addr_c >> MIN_ORDER) >= NGRAN);
	end

	// scan step, buddy and merge addresses
	always_comb begin
		hit_c   = ent.head && ent.free && (ent.order >= k_q)
			&& (!found_q || (ent.order < j_q));
		nxt_c   = {1'b0, ptr_q} + ((GW+1)'(1) << (ent.order - ORD_MIN));
		buddy_c = g_q ^ (GW'(1) << (k_q - ORD_MIN));
		lo_c    = (buddy_c < g_q) ? buddy_c : g_q;
		hi_c    = (buddy_c < g_q) ? g_q : buddy_c;
	end

	// status to the controller
	always_comb begin
		sts.act        = act_q;
		sts.too_big    = too_big_q;
		sts.k_big      = k_big_q;
		sts.pre_bad    = pre_bad_q;
		sts.scan_done  = nxt_c[GW] || (hit_c && (ent.order == k_q));
		sts.found      = found_q || hit_c;
		sts.split_more = j_q > k_q;
		sts.head_ok    = ent.head && !ent.free;
		sts.k_in       = (k_q >= ORD_MIN) && (k_q < ORD_ARENA);
		sts.merge_ok   = ent.head && ent.free && (ent.order == k_q);
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		we      = 1'b0;
		wa      = g_q;
		wd      = '0;
		case (cmd.op)
			OP_READ_PTR: begin
				rd_en = 1'b1;
			end
			OP_READ_G: begin
				rd_en   = 1'b1;
				rd_addr = g_q;
			end
			OP_READ_BUDDY: begin
				rd_en   = 1'b1;
				rd_addr = buddy_c;
			end
			OP_SPLIT: begin
				we = 1'b1;
				wa = g_q + (GW'(1) << (j_q - ORD_W'(MIN_ORDER + 1)));
				wd = '{head: 1'b1, free: 1'b1, order: j_q - ORD_W'(1)};
			end
			OP_GRANT: begin
				we = 1'b1;
				wd = '{head: 1'b1, free: 1'b0, order: k_q};
			end
			OP_MERGE: begin
				we = 1'b1;
				wa = hi_c;
			end
			OP_RELEASE: begin
				we = 1'b1;
				wd = '{head: 1'b1, free: 1'b1, order: k_q};
			end
			default: begin
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// valid bits and read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				rd_zero_q <= (rd_addr == '0);
			end
		end
	end

	assign off_c = (32'(g_q) << MIN_ORDER) + 32'(HEADER_BYTES);

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				act_q     <= in_data.action;
				too_big_q <= (32'(need_c) > 32'(BUDDY_LIMIT));
				k_big_q   <= (k_c > ORD_ARENA);
				k_q       <= k_c;
				pre_bad_q <= pre_bad_c;
				ptr_q     <= '0;
				found_q   <= 1'b0;
				g_q       <= GW'(addr_c >> MIN_ORDER);
			end
			OP_SCAN: begin
				ptr_q <= nxt_c[GW-1:0];
				if (hit_c) begin
					found_q <= 1'b1;
					g_q     <= ptr_q;
					j_q     <= ent.order;
				end
			end
			OP_SPLIT: begin
				j_q <= j_q - ORD_W'(1);
			end
			OP_CHECK: begin
				k_q <= ent.order;
			end
			OP_MERGE: begin
				g_q <= lo_c;
				k_q <= k_q + ORD_W'(1);
			end
			OP_RESULT: begin
				if (cmd.st == ST_OK) begin
					res_q <= '{status: ST_OK, data_offset: off_c[13:0],
						block_order: k_q[3:0]};
				end else begin
					res_q <= '{status: cmd.st, data_offset: '0, block_order: '0};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_data = res_q;

endmodule

`default_nettype wire

// ----- src/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl: allocator controller
// Sequences scan, split, free check and merge steps; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	input  bba_pkg::sts_t  sts,
	output bba_pkg::cmd_t  cmd
);
	import bba_pkg::*;

	state_t  state_q;
	state_t  state_d;
	status_t st_q;
	status_t st_d;
	logic    out_valid_q;
	logic    out_load;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		cmd.op   = OP_NONE;
		cmd.st   = st_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				if (sts.act == ACT_FREE) begin
					if (sts.pre_bad) begin
						st_d    = ST_INVALID;
						state_d = S_FIN;
					end else begin
						state_d = S_FR_RD;
					end
				end else if (sts.too_big) begin
					st_d    = ST_TOOBIG;
					state_d = S_FIN;
				end else if (sts.k_big) begin
					st_d    = ST_NOMEM;
					state_d = S_FIN;
				end else begin
					state_d = S_SC_RD;
				end
			end
			S_SC_RD: begin
				cmd.op  = OP_READ_PTR;
				state_d = S_SC_EV;
			end
			S_SC_EV: begin
				cmd.op = OP_SCAN;
				if (!sts.scan_done) begin
					state_d = S_SC_RD;
				end else if (sts.found) begin
					state_d = S_SPLIT;
				end else begin
					st_d    = ST_NOMEM;
					state_d = S_FIN;
				end
			end
			S_SPLIT: begin
				if (sts.split_more) begin
					cmd.op = OP_SPLIT;
				end else begin
					cmd.op  = OP_GRANT;
					st_d    = ST_OK;
					state_d = S_FIN;
				end
			end
			S_FR_RD: begin
				cmd.op  = OP_READ_G;
				state_d = S_FR_EV;
			end
			S_FR_EV: begin
				if (sts.head_ok) begin
					cmd.op  = OP_CHECK;
					state_d = S_BD_RD;
				end else begin
					st_d    = ST_INVALID;
					state_d = S_FIN;
				end
			end
			S_BD_RD: begin
				if (sts.k_in) begin
					cmd.op  = OP_READ_BUDDY;
					state_d = S_BD_EV;
				end else begin
					state_d = S_RELEASE;
				end
			end
			S_BD_EV: begin
				if (sts.merge_ok) begin
					cmd.op  = OP_MERGE;
					state_d = S_BD_RD;
				end else begin
					state_d = S_RELEASE;
				end
			end
			S_RELEASE: begin
				cmd.op  = OP_RELEASE;
				st_d    = ST_OK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_RESULT;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
